/* rtl/tosq_pkg.sv */
// ----------------------------------------------------------------------------
// tosq_pkg
// shared types, codes and defaults of the timed output sequence queue
// ----------------------------------------------------------------------------
package tosq_pkg;

    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam int DEF_PIN_WIDTH   = 32;

    // fixed field widths of the item ports
    localparam int FIELD_W = 32;
    localparam int DUR_W   = 32;

    // item function codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_ENQUEUE = 1'b1;

    // one input item as held in the input register
    typedef struct packed {
        logic               func;
        logic [DUR_W-1:0]   hold_ticks;
        logic [FIELD_W-1:0] pattern;
    } req_t;

    // result fields of fixed width, taken straight from the state registers
    typedef struct packed {
        logic [FIELD_W-1:0] pin_state;
        logic               accepted;
        logic               running;
    } status_t;

endpackage

/* rtl/tosq_ram.sv */
// ----------------------------------------------------------------------------
// tosq_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tosq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tosq_core.sv */
// ----------------------------------------------------------------------------
// tosq_core
// queue pointers, entry store, active operation timer and pin register
// ----------------------------------------------------------------------------
module tosq_core #(
    parameter int QUEUE_DEPTH = tosq_pkg::DEF_QUEUE_DEPTH,
    parameter int PIN_WIDTH   = tosq_pkg::DEF_PIN_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  tosq_pkg::req_t                   req,
    output tosq_pkg::status_t                status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = tosq_pkg::DUR_W + PIN_WIDTH;

    // control state
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             idle_reg, idle_next;
    logic             acc_reg, acc_next;
    logic             byp_reg;

    // payload state
    logic [tosq_pkg::DUR_W-1:0] elapsed_reg, elapsed_next;
    logic [tosq_pkg::DUR_W-1:0] act_dur_reg, act_dur_next;
    logic [PIN_WIDTH-1:0]       pin_reg, pin_next;
    logic [ENT_W-1:0]           byp_data_reg;

    logic [PIN_WIDTH-1:0]       pat_w;
    logic [tosq_pkg::FIELD_W-1:0] pin_out;
    logic [CNT_W-1:0]           count_dec;

    logic                       ram_we;
    logic [ENT_W-1:0]           ram_wdata;
    logic [ENT_W-1:0]           ram_rdata;
    logic [IDX_W-1:0]           ram_raddr;
    logic [ENT_W-1:0]           nxt_entry;
    logic [tosq_pkg::DUR_W-1:0] nxt_dur;
    logic [PIN_WIDTH-1:0]       nxt_pat;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // pattern and pin width conversion
    generate
        if (PIN_WIDTH >= tosq_pkg::FIELD_W)
        begin : g_wide_pins
            assign pat_w   = PIN_WIDTH'(req.pattern);
            assign pin_out = pin_reg[tosq_pkg::FIELD_W-1:0];
        end
        else
        begin : g_narrow_pins
            assign pat_w   = req.pattern[PIN_WIDTH-1:0];
            assign pin_out = tosq_pkg::FIELD_W'(pin_reg);
        end
    endgenerate

    // entry that follows the active one, with write bypass
    assign nxt_entry = byp_reg ? byp_data_reg : ram_rdata;
    assign nxt_dur   = nxt_entry[ENT_W-1:PIN_WIDTH];
    assign nxt_pat   = nxt_entry[PIN_WIDTH-1:0];
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        count_next   = count_reg;
        idle_next    = idle_reg;
        acc_next     = acc_reg;
        elapsed_next = elapsed_reg;
        act_dur_next = act_dur_reg;
        pin_next     = pin_reg;
        ram_we       = 1'b0;
        ram_wdata    = {req.hold_ticks, pat_w};
        if (fire)
        begin
            acc_next = 1'b0;
            case (req.func)
                tosq_pkg::FUNC_ENQUEUE:
                begin
                    if (count_reg != CNT_W'(QUEUE_DEPTH))
                    begin
                        ram_we      = 1'b1;
                        wr_idx_next = idx_inc(wr_idx_reg);
                        count_next  = count_reg + CNT_W'(1);
                        acc_next    = 1'b1;
                        if (idle_reg)
                        begin
                            idle_next    = 1'b0;
                            pin_next     = pat_w;
                            elapsed_next = '0;
                            act_dur_next = req.hold_ticks;
                        end
                    end
                end
                tosq_pkg::FUNC_TICK:
                begin
                    if (!idle_reg)
                    begin
                        if (elapsed_reg >= act_dur_reg)
                        begin
                            rd_idx_next = idx_inc(rd_idx_reg);
                            count_next  = count_dec;
                            if (count_dec != '0)
                            begin
                                pin_next     = nxt_pat;
                                elapsed_next = '0;
                                act_dur_next = nxt_dur;
                            end
                            else
                            begin
                                idle_next = 1'b1;
                            end
                        end
                        else
                        begin
                            elapsed_next = elapsed_reg + tosq_pkg::DUR_W'(1);
                        end
                    end
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    // always fetch the slot after the next head
    assign ram_raddr = idx_inc(rd_idx_next);

    tosq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            count_reg   <= '0;
            idle_reg    <= 1'b1;
            acc_reg     <= 1'b0;
            byp_reg     <= 1'b0;
            elapsed_reg <= '0;
            act_dur_reg <= '0;
            pin_reg     <= '0;
        end
        else
        begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            count_reg   <= count_next;
            idle_reg    <= idle_next;
            acc_reg     <= acc_next;
            byp_reg     <= ram_we && (wr_idx_reg == ram_raddr);
            elapsed_reg <= elapsed_next;
            act_dur_reg <= act_dur_next;
            pin_reg     <= pin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
    end

    assign status.pin_state = pin_out;
    assign status.accepted  = acc_reg;
    assign status.running   = !idle_reg;
    assign occupancy        = count_reg;

endmodule

/* rtl/timed_output_sequence_queue_unit.sv */
// ----------------------------------------------------------------------------
// timed_output_sequence_queue_unit
// queue of timed output patterns driven one after another by timer ticks
// ----------------------------------------------------------------------------
// Every input transfer is either a timer tick (func low) or an enqueue of an
// operation (func high) carrying a duration in ticks and an output pattern.
// Each item gives exactly one result transfer with the pin pattern after the
// step, the enqueue acceptance flag, the running flag and the number of
// queued operations, the active one included. An operation ends on the tick
// at which its elapsed count has reached its duration, so a duration of zero
// ends on the first tick and the next queued operation starts on that same
// tick. The block takes one item per clock cycle while its results are taken:
// an item sits in the input register while its step is worked out, the state
// moves at the edge on which that step fires, and its result stands in the
// output register right after that edge. A result that is not taken
// keeps the held item waiting, which in turn holds off the next input
// transfer. The queue store is a single ram with one registered read port
// that always prefetches the entry behind the active one, which is what lets
// two operations end on consecutive ticks. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module timed_output_sequence_queue_unit #(
    parameter int QUEUE_DEPTH = tosq_pkg::DEF_QUEUE_DEPTH,
    parameter int PIN_WIDTH   = tosq_pkg::DEF_PIN_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [tosq_pkg::DUR_W-1:0]       hold_ticks,
    input  logic [tosq_pkg::FIELD_W-1:0]     pattern,

    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tosq_pkg::FIELD_W-1:0]     pin_state,
    output logic                             accepted,
    output logic                             running,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

    tosq_pkg::req_t    req_reg;
    tosq_pkg::status_t status;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              step_fire;

    // the result register is free when empty or being taken this cycle
    assign out_free  = !out_valid_reg || out_ready;
    // apply the held item once its result has somewhere to go
    assign step_fire = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || step_fire;

    // input register, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input register, payload part
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg.func       <= func;
            req_reg.hold_ticks <= hold_ticks;
            req_reg.pattern    <= pattern;
        end
    end

    // state registers only move on a step, which only fires once the old result
    // is gone or being taken, so they serve as the result register themselves
    tosq_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PIN_WIDTH   (PIN_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (step_fire),
        .req       (req_reg),
        .status    (status),
        .occupancy (occupancy)
    );

    assign out_valid = out_valid_reg;
    assign pin_state = status.pin_state;
    assign accepted  = status.accepted;
    assign running   = status.running;

endmodule

/* test/timed_output_sequence_queue_unit_test.sv */
// ----------------------------------------------------------------------------
// timed_output_sequence_queue_unit_test
// self-checking bench for the queue of timed output patterns
// ----------------------------------------------------------------------------
// Ticks and enqueues go in through the input channel. Every accepted item
// runs through a model of the queue inside a small scoreboard class, which
// keeps the expected status for that step. Each status transfer on the
// result channel is then checked field by field against the oldest one. The
// stimulus starts with a short list of hand-picked items. Random traffic
// follows in phases: mixed traffic, a fill up to a full queue that wraps the
// write index with rejected enqueues on top, a partial drain, and a closing
// mix with very long durations. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module timed_output_sequence_queue_unit_test;

    localparam int QUEUE_DEPTH = tosq_pkg::DEF_QUEUE_DEPTH;
    localparam int PIN_WIDTH   = tosq_pkg::DEF_PIN_WIDTH;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    // only the low pin bits of a pattern are kept by the block
    localparam logic [tosq_pkg::FIELD_W-1:0] PIN_MASK =
        {tosq_pkg::FIELD_W{1'b1}} >> (tosq_pkg::FIELD_W - PIN_WIDTH);

    // run length guard and settle time after the last result
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_TICKS = 10;

    // status that the block shows after one step
    typedef struct packed {
        logic [tosq_pkg::FIELD_W-1:0] pin_state;
        logic                         accepted;
        logic                         running;
        logic [OCC_W-1:0]             occupancy;
    } step_status_t;

    // ------------------------------------------------------------------------
    // queue model and the list of status transfers still to come
    // ------------------------------------------------------------------------
    class pin_sequence_tracker;
        logic [tosq_pkg::DUR_W-1:0]   duration_mem [QUEUE_DEPTH];
        logic [tosq_pkg::FIELD_W-1:0] pattern_mem  [QUEUE_DEPTH];
        int unsigned                  wr_idx;
        int unsigned                  rd_idx;
        int unsigned                  count;
        bit                           idle;
        logic [tosq_pkg::DUR_W-1:0]   elapsed_ticks;
        logic [tosq_pkg::FIELD_W-1:0] pins;
        step_status_t                 expected_status_q [$];
        int unsigned                  mismatch_count;
        int unsigned                  status_seen;

        function new();
            wr_idx         = 0;
            rd_idx         = 0;
            count          = 0;
            idle           = 1'b1;
            elapsed_ticks  = '0;
            pins           = '0;
            mismatch_count = 0;
            status_seen    = 0;
        endfunction

        // apply one accepted item to the model and queue up its status
        function void predict_step(logic f, logic [tosq_pkg::DUR_W-1:0] hold,
                                   logic [tosq_pkg::FIELD_W-1:0] pat);
            step_status_t st;
            logic         took;
            took = 1'b0;
            if (f == tosq_pkg::FUNC_ENQUEUE) begin
                if (count < QUEUE_DEPTH) begin
                    duration_mem[wr_idx] = hold;
                    pattern_mem[wr_idx]  = pat & PIN_MASK;
                    if (idle) begin
                        idle          = 1'b0;
                        pins          = pattern_mem[wr_idx];
                        elapsed_ticks = '0;
                    end
                    wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
                    count++;
                    took = 1'b1;
                end
            end
            else if (!idle) begin
                // the active operation ends once elapsed has reached its duration
                if (elapsed_ticks >= duration_mem[rd_idx]) begin
                    rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
                    count--;
                    if (count > 0) begin
                        pins          = pattern_mem[rd_idx];
                        elapsed_ticks = '0;
                    end
                    else begin
                        idle = 1'b1;
                    end
                end
                else begin
                    elapsed_ticks++;
                end
            end
            st.pin_state = pins;
            st.accepted  = took;
            st.running   = !idle;
            st.occupancy = count[OCC_W-1:0];
            expected_status_q.push_back(st);
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("mismatch at status %0d: %s", status_seen, msg);
        endtask

        // compare one status transfer with the oldest expectation
        task check_status(logic [tosq_pkg::FIELD_W-1:0] pin, logic acc, logic run,
                          logic [OCC_W-1:0] occ);
            step_status_t want;
            status_seen++;
            if (expected_status_q.size() == 0) begin
                report_mismatch($sformatf("unexpected status, pin_state %h", pin));
                return;
            end
            want = expected_status_q.pop_front();
            if (pin !== want.pin_state)
                report_mismatch($sformatf("pin_state %h, want %h", pin, want.pin_state));
            if (acc !== want.accepted)
                report_mismatch($sformatf("accepted %b, want %b", acc, want.accepted));
            if (run !== want.running)
                report_mismatch($sformatf("running %b, want %b", run, want.running));
            if (occ !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, want %0d", occ, want.occupancy));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // block signals
    // ------------------------------------------------------------------------
    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic                         func;
    logic [tosq_pkg::DUR_W-1:0]   hold_ticks;
    logic [tosq_pkg::FIELD_W-1:0] pattern;
    logic                         out_valid;
    logic                         out_ready;
    logic [tosq_pkg::FIELD_W-1:0] pin_state;
    logic                         accepted;
    logic                         running;
    logic [OCC_W-1:0]             occupancy;

    pin_sequence_tracker tracker;

    // calm stretches switch idling off on both sides for a while
    bit          calm = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    timed_output_sequence_queue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PIN_WIDTH   (PIN_WIDTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .hold_ticks (hold_ticks),
        .pattern    (pattern),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pin_state  (pin_state),
        .accepted   (accepted),
        .running    (running),
        .occupancy  (occupancy)
    );

    // 10 time unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run length guard, a hung handshake ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // one input transfer: optional idle gap, then valid held with a steady
    // payload until ready is seen at a rising edge. valid is left high so a
    // following item with no gap goes out without a drop in between
    task automatic send_item(input logic f, input logic [tosq_pkg::DUR_W-1:0] hold,
                             input logic [tosq_pkg::FIELD_W-1:0] pat);
        int unsigned gap;
        if (items_sent % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        hold_ticks <= hold;
        pattern    <= pat;
        do @(posedge clk); while (!in_ready);
        tracker.predict_step(f, hold, pat);
        items_sent++;
    endtask

    // ticks carry random junk in the unused fields
    task automatic send_tick();
        send_item(tosq_pkg::FUNC_TICK, $urandom, $urandom);
    endtask

    // durations mostly short so the queue keeps moving
    function automatic logic [tosq_pkg::DUR_W-1:0] short_hold();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(0, 4);
        else if (sel < 97)
            return $urandom_range(5, 20);
        else
            return $urandom_range(21, 200);
    endfunction

    // mixed traffic, leaning toward ticks once the queue has grown
    task automatic mixed_traffic(input int unsigned n);
        int unsigned share;
        repeat (n)
        begin
            share = (tracker.count > 24) ? 20 : 50;
            if ($urandom_range(0, 99) < share)
                send_item(tosq_pkg::FUNC_ENQUEUE, short_hold(), $urandom);
            else
                send_tick();
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: each result draws its own stall before ready goes high
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 18);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // every status transfer is checked at the edge that takes it
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_status(pin_state, accepted, running, occupancy);
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        tracker    = new();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        func       <= tosq_pkg::FUNC_TICK;
        hold_ticks <= '0;
        pattern    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // tick with nothing queued does nothing
        send_tick();
        // zero duration ends on the first tick, pins keep the last pattern
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd0, 32'hFFFF_FFFF);
        send_tick();
        send_tick();
        // three queued operations handed over one after another
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd2, 32'h0000_0000);
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd0, 32'hA5A5_A5A5);
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd1, 32'h5A5A_5A5A);
        repeat (6) send_tick();
        // two zero-duration operations ending on consecutive ticks
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd0, 32'h8000_0001);
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd0, 32'h7FFF_FFFE);
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd1, 32'h0000_FFFF);
        send_tick();
        send_tick();
        // enqueue while the last one is still counting
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'd0, 32'hFFFF_0000);
        repeat (4) send_tick();

        mixed_traffic(100);

        // fill to the brim, then enqueues on a full queue get turned away
        while (tracker.count < QUEUE_DEPTH)
        begin
            if ($urandom_range(0, 99) < 97)
                send_item(tosq_pkg::FUNC_ENQUEUE,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                          $urandom);
            else
                send_tick();
        end
        repeat (6) send_item(tosq_pkg::FUNC_ENQUEUE, $urandom, $urandom);

        // work off part of the full queue
        repeat (40) send_tick();

        mixed_traffic(50);

        // very long durations last, they hold the queue for the rest of the run
        send_item(tosq_pkg::FUNC_ENQUEUE, $urandom, $urandom);
        send_item(tosq_pkg::FUNC_ENQUEUE, 32'hFFFF_FFFF, $urandom);
        send_item(tosq_pkg::FUNC_ENQUEUE, $urandom, 32'h0000_0000);
        repeat (20) send_tick();

        // last transfer done, let the remaining status transfers come out
        in_valid <= 1'b0;
        while (tracker.expected_status_q.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (tracker.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
